### src/rpsr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rpsr_pkg;

  // Ring geometry
  localparam int SLOTS      = 8;
  localparam int SLOT_BYTES = 256;

  localparam int SlotW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CountW = $clog2(SLOTS + 1);
  localparam int PosW   = $clog2(SLOT_BYTES + 1);
  localparam int Depth  = SLOTS * SLOT_BYTES;
  localparam int AddrW  = (Depth > 1) ? $clog2(Depth) : 1;

  // Fixed field widths
  localparam int CfgW   = 4;
  localparam int ByteW  = 8;
  localparam int OffW   = 8;
  localparam int LenW   = 9;
  localparam int DropW  = 16;

  typedef enum logic [1:0] {
    KIND_RX    = 2'd0,
    KIND_READ  = 2'd1,
    KIND_MARK  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_e;

  // Step a slot index, wrapping at the active slot count
  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] idx,
                                                 input logic [CountW-1:0] count);
    logic [CountW:0] nx;
    nx = (CountW+1)'(idx) + (CountW+1)'(1);
    if (nx >= (CountW+1)'(count)) begin
      next_slot = '0;
    end else begin
      next_slot = SlotW'(nx);
    end
  endfunction

endpackage

`default_nettype wire

### src/rx_packet_slot_ring.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------------------------
// item in   | start, busy               | kind_i, rx_byte_i, rx_last_i, read_offset_i
// result    | result_strobe_o (1 cycle) | head_ready_o, head_length_o, read_data_o,
//           |                           | dropped_count_o
// config    | cfg_valid_i, cfg_ready_o  | cfg_data_i (slots in use)
//
// An item is taken at an edge with start high and busy low; its result shows on the
// cycle right after, so one word per cycle flows in and one out. The registered result
// comes from the synchronous byte memory: a head read is launched at the accept edge
// and its data is registered at that same edge. Reset clears the slot flags, lengths,
// ring pointers and drop count at once; the byte memory is not cleared, since a byte is
// only reported below its slot's stored length. The receiver cannot stall results.

module rx_packet_slot_ring
  import rpsr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,

  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        kind_i,
  input  wire logic [ByteW-1:0]  rx_byte_i,
  input  wire logic              rx_last_i,
  input  wire logic [OffW-1:0]   read_offset_i,

  output logic                   result_strobe_o,
  output logic                   head_ready_o,
  output logic [LenW-1:0]        head_length_o,
  output logic [ByteW-1:0]       read_data_o,
  output logic [DropW-1:0]       dropped_count_o,

  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [CfgW-1:0]   cfg_data_i
);

  // The block takes every item as it comes, so it never holds off a word.
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic accept;
  assign accept = start && !busy;

  kind_e kind;
  assign kind = kind_e'(kind_i);

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  logic [CfgW-1:0]  cfg_q;
  logic [SLOTS-1:0] ready_q, ready_d;
  logic [PosW-1:0]  len_q [SLOTS];
  logic [SlotW-1:0] wr_slot_q, wr_slot_d;
  logic [SlotW-1:0] rd_slot_q, rd_slot_d;
  logic [DropW-1:0] drop_q, drop_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             disc_q, disc_d;
  logic             strobe_q;
  logic             rd_hit_q, rd_hit_d;
  logic [ByteW-1:0] rdata_q;

  // Byte memory: one write port for received bytes, one registered read port.
  logic [ByteW-1:0] mem [Depth];
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;

  // Length update for the packet closed by this item
  logic             len_we;

  // Clamp the configured slot count into 1..SLOTS.
  logic [CountW-1:0] ring_count;
  always_comb begin
    if (cfg_q == '0) begin
      ring_count = CountW'(1);
    end else if (32'(cfg_q) > SLOTS) begin
      ring_count = CountW'(SLOTS);
    end else begin
      ring_count = CountW'(cfg_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Item processing
  // ---------------------------------------------------------------------------
  logic            start_drop;
  logic            disc_now;
  logic [PosW-1:0] pos_next;

  always_comb begin
    ready_d   = ready_q;
    wr_slot_d = wr_slot_q;
    rd_slot_d = rd_slot_q;
    drop_d    = drop_q;
    pos_d     = pos_q;
    disc_d    = disc_q;
    rd_hit_d  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    len_we    = 1'b0;

    // A packet that opens on a still-occupied slot is dropped whole.
    start_drop = (pos_q == '0) && !disc_q && ready_q[wr_slot_q];
    disc_now   = disc_q || start_drop;
    pos_next   = pos_q;

    mem_waddr = AddrW'(32'(wr_slot_q) * SLOT_BYTES + 32'(pos_q));
    mem_raddr = AddrW'(32'(rd_slot_q) * SLOT_BYTES + 32'(read_offset_i));

    if (accept) begin
      case (kind)
        KIND_RX: begin
          if (start_drop && (drop_q != '1)) begin
            drop_d = drop_q + DropW'(1);
          end
          // Store the byte unless dropping or past the slot end (truncate).
          if (!disc_now && (32'(pos_q) < SLOT_BYTES)) begin
            mem_we   = 1'b1;
            pos_next = pos_q + PosW'(1);
          end
          if (rx_last_i) begin
            if (!disc_now && (pos_next != '0)) begin
              len_we               = 1'b1;
              ready_d[wr_slot_q]   = 1'b1;
              wr_slot_d            = next_slot(wr_slot_q, ring_count);
            end
            pos_d  = '0;
            disc_d = 1'b0;
          end else begin
            pos_d  = pos_next;
            disc_d = disc_now;
          end
        end
        KIND_READ: begin
          mem_re   = 1'b1;
          rd_hit_d = (32'(read_offset_i) < 32'(len_q[rd_slot_q]))
                     && (32'(read_offset_i) < SLOT_BYTES);
        end
        KIND_MARK: begin
          // Release the head and advance, whether or not it held a packet.
          ready_d[rd_slot_q] = 1'b0;
          rd_slot_d          = next_slot(rd_slot_q, ring_count);
        end
        KIND_CLEAR: begin
          drop_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q     <= CfgW'(SLOTS);
      ready_q   <= '0;
      wr_slot_q <= '0;
      rd_slot_q <= '0;
      drop_q    <= '0;
      pos_q     <= '0;
      disc_q    <= 1'b0;
      strobe_q  <= 1'b0;
      rd_hit_q  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      ready_q   <= ready_d;
      wr_slot_q <= wr_slot_d;
      rd_slot_q <= rd_slot_d;
      drop_q    <= drop_d;
      pos_q     <= pos_d;
      disc_q    <= disc_d;
      strobe_q  <= accept;
      rd_hit_q  <= rd_hit_d;
      if (len_we) begin
        len_q[wr_slot_q] <= pos_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= rx_byte_i;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Result word: state after the item, shown in the cycle after accept
  // ---------------------------------------------------------------------------
  assign result_strobe_o = strobe_q;
  assign head_ready_o    = ready_q[rd_slot_q];
  assign head_length_o   = LenW'(len_q[rd_slot_q]);
  assign read_data_o     = rd_hit_q ? rdata_q : '0;
  assign dropped_count_o = drop_q;

endmodule

`default_nettype wire

### src/rpsr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rpsr_checker
  import rpsr_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [1:0]       kind_i,
  input wire logic             result_strobe_o,
  input wire logic             head_ready_o,
  input wire logic [LenW-1:0]  head_length_o,
  input wire logic [ByteW-1:0] read_data_o,
  input wire logic [DropW-1:0] dropped_count_o
);

  // Each accepted word yields exactly one result on the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> result_strobe_o)
    else $error("result strobe missing after accepted word");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(start && !busy))
    else $error("result strobe without accepted word");

  // Head status and drop count only move with a result.
  a_state_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_strobe_o |-> ($stable(dropped_count_o) && $stable(head_ready_o)
                          && $stable(head_length_o)))
    else $error("status changed without a result");

  // Drop count falls only on a clear word.
  a_drop_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && (dropped_count_o < $past(dropped_count_o)))
      |-> ($past(kind_i) == KIND_CLEAR))
    else $error("drop count decreased without clear");

  a_read_data_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_strobe_o |-> (read_data_o == '0))
    else $error("read data driven outside a result");

endmodule

bind rx_packet_slot_ring rpsr_checker u_rpsr_checker (.*);

`default_nettype wire

### bench/tb_rx_packet_slot_ring.sv
`timescale 1ns / 1ps

// Bench for the received-packet slot ring.
//
// Words go in over the start/busy handshake; every accepted word yields exactly one
// head-status word in the next cycle, flagged by result_strobe_o. The bench keeps its own
// copy of the ring (bytes, ready flags, lengths, pointers, drop tally, fill position and
// the drop-in-progress flag), steps it on every accepted word and queues the head status
// it expects. A checker pops that queue on every strobe and compares field by field.
// The slot count register is only written once the ring has gone quiet.

module tb_rx_packet_slot_ring;
  import rpsr_pkg::*;

  localparam int CycleLimit = 3_000_000;
  localparam int TailCycles = 4;
  localparam int GapPct     = 32;

  typedef struct packed {
    logic             ready;
    logic [LenW-1:0]  length;
    logic [ByteW-1:0] data;
    logic [DropW-1:0] drops;
  } head_status_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        kind_i;
  logic [ByteW-1:0]  rx_byte_i;
  logic              rx_last_i;
  logic [OffW-1:0]   read_offset_i;
  logic              result_strobe_o;
  logic              head_ready_o;
  logic [LenW-1:0]   head_length_o;
  logic [ByteW-1:0]  read_data_o;
  logic [DropW-1:0]  dropped_count_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CfgW-1:0]   cfg_data_i;

  rx_packet_slot_ring u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .rx_byte_i       (rx_byte_i),
    .rx_last_i       (rx_last_i),
    .read_offset_i   (read_offset_i),
    .result_strobe_o (result_strobe_o),
    .head_ready_o    (head_ready_o),
    .head_length_o   (head_length_o),
    .read_data_o     (read_data_o),
    .dropped_count_o (dropped_count_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the ring
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] byte_store [SLOTS*SLOT_BYTES];
  logic             slot_full  [SLOTS];
  logic [LenW-1:0]  slot_len   [SLOTS];
  int               wr_slot;
  int               rd_slot;
  logic [DropW-1:0] drop_tally;
  int               fill_pos;
  bit               dropping;
  logic [CfgW-1:0]  ring_size;

  head_status_t     heads_in_flight[$];
  bit               failed;
  bit               gaps_on;
  int               words_sent;
  int               cycle_count;

  int               sizes_long [2] = '{256, 259};

  // Slot count in effect: zero acts as one, anything past SLOTS acts as SLOTS.
  function automatic int ring_span();
    int n;
    n = ring_size;
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    return n;
  endfunction

  // Step a pointer; anything at or past the span falls back to slot 0.
  function automatic int ring_next(int idx);
    return (idx + 1 >= ring_span()) ? 0 : idx + 1;
  endfunction

  // Apply one accepted word to the shadow ring and return the head status it leaves.
  function automatic head_status_t apply_word_to_ring(kind_e k, logic [ByteW-1:0] b,
                                                      logic last, logic [OffW-1:0] off);
    head_status_t st;
    st.data = '0;
    case (k)
      KIND_RX: begin
        // First byte into a slot that is still occupied: drop the whole packet once.
        if (fill_pos == 0 && !dropping && slot_full[wr_slot]) begin
          dropping = 1'b1;
          if (drop_tally != '1) drop_tally = drop_tally + 1'b1;
        end
        // Past the slot size the packet is truncated.
        if (!dropping && fill_pos < SLOT_BYTES) begin
          byte_store[wr_slot*SLOT_BYTES + fill_pos] = b;
          fill_pos++;
        end
        if (last) begin
          if (!dropping && fill_pos > 0) begin
            slot_len[wr_slot]  = LenW'(fill_pos);
            slot_full[wr_slot] = 1'b1;
            wr_slot = ring_next(wr_slot);
          end
          fill_pos = 0;
          dropping = 1'b0;
        end
      end
      KIND_READ: begin
        // Bytes are reported below the stored length whether the slot is ready or not.
        if (off < slot_len[rd_slot]) st.data = byte_store[rd_slot*SLOT_BYTES + off];
      end
      KIND_MARK: begin
        // The read pointer advances even over an empty head.
        slot_full[rd_slot] = 1'b0;
        rd_slot = ring_next(rd_slot);
      end
      default: begin
        drop_tally = '0;
      end
    endcase
    st.ready  = slot_full[rd_slot];
    st.length = slot_len[rd_slot];
    st.drops  = drop_tally;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver side
  // ---------------------------------------------------------------------------

  // Present one word and hold it until busy is low at an edge. start stays high on
  // return so back-to-back words never toggle it within one time step.
  task automatic send_word(kind_e k, logic [ByteW-1:0] b, logic last,
                           logic [OffW-1:0] off);
    if (gaps_on) begin
      while ($urandom_range(99) < GapPct) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
    end
    start         <= 1'b1;
    kind_i        <= k;
    rx_byte_i     <= b;
    rx_last_i     <= last;
    read_offset_i <= off;
    do @(posedge clk_i); while (busy);
    heads_in_flight.push_back(apply_word_to_ring(k, b, last, off));
    words_sent++;
  endtask

  // Unused fields always carry random values so every port bit toggles.
  task automatic rx_word(logic [ByteW-1:0] b, logic last);
    send_word(KIND_RX, b, last, OffW'($urandom));
  endtask

  task automatic read_head(logic [OffW-1:0] off);
    send_word(KIND_READ, ByteW'($urandom), 1'($urandom), off);
  endtask

  task automatic mark_head();
    send_word(KIND_MARK, ByteW'($urandom), 1'($urandom), OffW'($urandom));
  endtask

  task automatic clear_drops();
    send_word(KIND_CLEAR, ByteW'($urandom), 1'($urandom), OffW'($urandom));
  endtask

  // Pick an offset: mostly inside the head packet, sometimes right at its end, else anywhere.
  function automatic logic [OffW-1:0] pick_offset();
    int len;
    int r;
    len = slot_len[rd_slot];
    r   = $urandom_range(99);
    if (r < 70 && len > 0) return OffW'($urandom_range(len - 1, 0));
    if (r < 85 && len < 256) return OffW'(len);
    return OffW'($urandom);
  endfunction

  // Drop start, wait for every queued status to come back, then let the pipe empty.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (heads_in_flight.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Write the slot count; the ring is settled first, so it is quiet when written.
  task automatic set_ring_size(logic [CfgW-1:0] n);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= CfgW'($urandom);
    ring_size = n;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked words on a one-slot ring: empty head, full-ring drop, reads past the
  // length, reads of a marked slot, and a zero slot count acting as one.
  task automatic test_single_slot_corners();
    set_ring_size(CfgW'(1));
    read_head(OffW'(0));
    mark_head();
    rx_word(8'h00, 1'b1);
    read_head(OffW'(0));
    rx_word(8'hFF, 1'b0);
    rx_word(8'h5A, 1'b0);
    rx_word(8'hA5, 1'b1);
    read_head(OffW'(1));
    read_head(OffW'(255));
    mark_head();
    read_head(OffW'(0));
    rx_word(8'hFF, 1'b0);
    rx_word(8'h80, 1'b1);
    read_head(OffW'(1));
    read_head(OffW'(0));
    clear_drops();
    set_ring_size(CfgW'(0));
    rx_word(8'h01, 1'b1);
    mark_head();
    rx_word(8'h7F, 1'b1);
    read_head(OffW'(0));
    clear_drops();
  endtask

  // Random traffic: mostly whole packets with random content, interleaved with reads,
  // marks and clears, plus some unfinished packets and raw noise words.
  task automatic run_traffic(int count);
    int target;
    int r;
    int len;
    bit cut;
    target = words_sent + count;
    while (words_sent < target) begin
      r = $urandom_range(99);
      if (r < 50) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
        cut = ($urandom_range(19) == 0);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(99) < 8) begin
            if ($urandom_range(1)) read_head(pick_offset());
            else mark_head();
          end
          rx_word(ByteW'($urandom), (i == len - 1) && !cut);
        end
      end else if (r < 75) begin
        repeat ($urandom_range(3, 1)) read_head(pick_offset());
      end else if (r < 90) begin
        mark_head();
      end else if (r < 94) begin
        clear_drops();
      end else begin
        send_word(kind_e'($urandom_range(3)), ByteW'($urandom), 1'($urandom),
                  OffW'($urandom));
      end
    end
  endtask

  // Step through slot counts, extremes included; one phase runs with no gaps at all.
  // Shrinking the count mid-run leaves pointers past the new wrap point.
  task automatic test_slot_count_phases();
    logic [CfgW-1:0] sizes [9];
    sizes = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd1, 4'd8, 4'd2, 4'd6};
    foreach (sizes[i]) begin
      set_ring_size(sizes[i]);
      gaps_on = (i != 6);
      run_traffic(55);
    end
    gaps_on = 1'b1;
    repeat (2) begin
      set_ring_size(CfgW'($urandom));
      run_traffic(55);
    end
  endtask

  // Fill one slot exactly and send one packet three bytes past its size, then read near the end.
  task automatic test_truncation();
    set_ring_size(CfgW'(8));
    if (fill_pos != 0 || dropping) rx_word(ByteW'($urandom), 1'b1);
    repeat (8) mark_head();
    while (rd_slot != wr_slot) mark_head();
    foreach (sizes_long[i]) begin
      for (int j = 0; j < sizes_long[i]; j++) begin
        rx_word(ByteW'($urandom), j == sizes_long[i] - 1);
      end
      read_head(OffW'(255));
      read_head(OffW'(254));
      read_head(OffW'(0));
      repeat (3) read_head(OffW'($urandom));
      mark_head();
    end
  endtask

  // Pile up drops back to back on a full one-slot ring, then clear them.
  task automatic test_drop_burst();
    set_ring_size(CfgW'(1));
    rx_word(ByteW'($urandom), 1'b1);
    gaps_on = 1'b0;
    repeat (30) rx_word(ByteW'($urandom), 1'b1);
    rx_word(ByteW'($urandom), 1'b0);
    rx_word(ByteW'($urandom), 1'b1);
    read_head(OffW'(0));
    clear_drops();
    rx_word(ByteW'($urandom), 1'b1);
    gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe pops the oldest queued status
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failed = 1'b1;
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    head_status_t want;
    if (rst_ni && result_strobe_o) begin
      if (heads_in_flight.size() == 0) begin
        $display("%0t: result word with nothing pending, expected none, actual %0d/%0d/%0d/%0d",
                 $time, head_ready_o, head_length_o, read_data_o, dropped_count_o);
        failed = 1'b1;
      end else begin
        want = heads_in_flight.pop_front();
        check_field("head_ready", want.ready, head_ready_o);
        check_field("head_length", want.length, head_length_o);
        check_field("read_data", want.data, read_data_o);
        check_field("dropped_count", want.drops, dropped_count_o);
      end
    end
  end

  // Hard stop if the ring hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    cycle_count   = 0;
    failed        = 1'b0;
    gaps_on       = 1'b1;
    words_sent    = 0;
    wr_slot       = 0;
    rd_slot       = 0;
    drop_tally    = '0;
    fill_pos      = 0;
    dropping      = 1'b0;
    ring_size     = CfgW'(8);
    foreach (slot_full[i]) begin
      slot_full[i] = 1'b0;
      slot_len[i]  = '0;
    end
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    kind_i        <= KIND_RX;
    rx_byte_i     <= '0;
    rx_last_i     <= 1'b0;
    read_offset_i <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_slot_corners();
    test_slot_count_phases();
    test_truncation();
    test_drop_burst();

    settle();
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
